FILE: rtl/core/strict_priority_block_queue_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the strict-priority block queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_BLOCK_QUEUE_CORE_MACROS_SVH
`define STRICT_PRIORITY_BLOCK_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPBQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spbq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPBQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spbq: next-cycle check failed");

`endif

FILE: rtl/core/spbq_pkg.sv
// ---------------------------------------------------------------------------
// Strict-priority block queue package
// Payload types, operation and status codes, and default parameter values.
// ---------------------------------------------------------------------------
`default_nettype none

package spbq_pkg;

  // Default values for the top-level parameters.
  localparam int DEF_LEVELS      = 4;
  localparam int DEF_MAX_DEPTH   = 256;
  localparam int DEF_BLOCK_BYTES = 8;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int PRIO_W   = 3;
  localparam int DATA_W   = 64;
  localparam int LEN_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OLEN_W   = 4;
  localparam int SERVED_W = 2;
  localparam int TOTAL_W  = 9;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd256;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ROOM  = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PRIO_W-1:0] priority_req;
    logic [DATA_W-1:0] block_data;
    logic [LEN_W-1:0]  block_length;
    logic [LEN_W-1:0]  room;
  } spbq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   out_data;
    logic [OLEN_W-1:0]   out_length;
    logic [SERVED_W-1:0] served_level;
  } spbq_out_t;

  // One stored block: its bytes and its length.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [OLEN_W-1:0] len;
  } spbq_entry_t;

  // Level state update issued when an operation completes.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } spbq_cmd_t;

  // Keeps the bytes below len and zeroes the rest.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [OLEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (OLEN_W'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/spbq_ram.sv
// ---------------------------------------------------------------------------
// Block store memory
// Single write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module spbq_ram #(
  parameter int ADDR_W = 10
) (
  input  wire                      clk,
  input  wire                      wr_en_i,
  input  wire [ADDR_W-1:0]         wr_addr_i,
  input  spbq_pkg::spbq_entry_t    wr_entry_i,
  input  wire [ADDR_W-1:0]         rd_addr_i,
  output spbq_pkg::spbq_entry_t    rd_entry_o
);
  import spbq_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  spbq_entry_t mem_r [DEPTH];
  spbq_entry_t rd_entry_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem_r[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read port, read on every cycle.
  always_ff @(posedge clk) begin
    rd_entry_r <= mem_r[rd_addr_i];
  end

  assign rd_entry_o = rd_entry_r;

endmodule

`default_nettype wire

FILE: rtl/core/spbq_levels.sv
// ---------------------------------------------------------------------------
// Per-level queue state
// Holds read and write pointers, fill counts and the capacity register, and
// works out the capacity and pointers of the level being looked up.
// ---------------------------------------------------------------------------
`default_nettype none
`include "strict_priority_block_queue_core_macros.svh"

module spbq_levels #(
  parameter int LEVELS    = spbq_pkg::DEF_LEVELS,
  parameter int MAX_DEPTH = spbq_pkg::DEF_MAX_DEPTH,
  parameter int LVL_W     = $clog2(LEVELS),
  parameter int PTR_W     = $clog2(MAX_DEPTH),
  parameter int CNT_W     = $clog2(MAX_DEPTH + 1)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire [spbq_pkg::TOTAL_W-1:0]    cfg_wr_data,
  input  wire [LVL_W-1:0]                lk_lvl_i,
  input  spbq_pkg::spbq_cmd_t            cmd_i,
  output logic [LVL_W-1:0]               pop_lvl_o,
  output logic                           any_ne_o,
  output logic [PTR_W-1:0]               lk_rptr_o,
  output logic [PTR_W-1:0]               lk_wptr_o,
  output logic [CNT_W-1:0]               lk_fill_o,
  output logic [CNT_W-1:0]               lk_cap_o
);
  import spbq_pkg::*;

  localparam int LO     = 1 << (LEVELS - 1);
  localparam int CALC_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

  logic [TOTAL_W-1:0] total_r;
  logic [PTR_W-1:0]   rptr_r  [LEVELS];
  logic [PTR_W-1:0]   wptr_r  [LEVELS];
  logic [CNT_W-1:0]   fill_r  [LEVELS];
  logic [PTR_W-1:0]   rptr_nxt [LEVELS];
  logic [PTR_W-1:0]   wptr_nxt [LEVELS];
  logic [CNT_W-1:0]   fill_nxt [LEVELS];
  logic [LEVELS-1:0]  ne;
  logic [CALC_W-1:0]  t_ext;
  logic [CALC_W-1:0]  t_lo;
  logic [CALC_W-1:0]  t_clamp;
  logic [CALC_W-1:0]  c_shift;
  logic [LVL_W-1:0]   sh;
  logic [CNT_W-1:0]   rptr_inc;
  logic [CNT_W-1:0]   wptr_inc;

  // Non-empty flags and the highest-priority non-empty level.
  always_comb begin
    pop_lvl_o = '0;
    for (int i = 0; i < LEVELS; i++) begin
      ne[i] = (fill_r[i] != '0);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne[i]) begin
        pop_lvl_o = LVL_W'(i);
      end
    end
    any_ne_o = |ne;
  end

  // Capacity of the looked-up level: clamped total shifted by its distance
  // from the lowest level, never below one block.
  always_comb begin
    t_ext   = CALC_W'(total_r);
    t_lo    = (t_ext < CALC_W'(LO)) ? CALC_W'(LO) : t_ext;
    t_clamp = (t_lo > CALC_W'(MAX_DEPTH)) ? CALC_W'(MAX_DEPTH) : t_lo;
    sh      = LVL_W'(LEVELS - 1) - lk_lvl_i;
    c_shift = t_clamp >> sh;
    lk_cap_o = (c_shift == '0) ? CNT_W'(1) : CNT_W'(c_shift);
  end

  assign lk_rptr_o = rptr_r[lk_lvl_i];
  assign lk_wptr_o = wptr_r[lk_lvl_i];
  assign lk_fill_o = fill_r[lk_lvl_i];
  assign rptr_inc  = CNT_W'(lk_rptr_o) + CNT_W'(1);
  assign wptr_inc  = CNT_W'(lk_wptr_o) + CNT_W'(1);

  // Pointer and count updates; a capacity write or a clear empties all levels.
  always_comb begin
    rptr_nxt = rptr_r;
    wptr_nxt = wptr_r;
    fill_nxt = fill_r;
    if (cfg_wr_en || cmd_i.clear) begin
      for (int i = 0; i < LEVELS; i++) begin
        rptr_nxt[i] = '0;
        wptr_nxt[i] = '0;
        fill_nxt[i] = '0;
      end
    end else if (cmd_i.push) begin
      wptr_nxt[lk_lvl_i] = (wptr_inc == lk_cap_o) ? '0 : PTR_W'(wptr_inc);
      fill_nxt[lk_lvl_i] = lk_fill_o + CNT_W'(1);
    end else if (cmd_i.pop) begin
      rptr_nxt[lk_lvl_i] = (rptr_inc == lk_cap_o) ? '0 : PTR_W'(rptr_inc);
      fill_nxt[lk_lvl_i] = lk_fill_o - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        rptr_r[i] <= '0;
        wptr_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // A push only lands in a level with space, and a pop only leaves a
  // non-empty one.
  `SPBQ_ASSERT_NOW(a_push_has_space, cmd_i.push, lk_fill_o < lk_cap_o)
  `SPBQ_ASSERT_NOW(a_pop_has_data, cmd_i.pop, lk_fill_o != '0)
  // The looked-up level never holds more than its capacity.
  `SPBQ_ASSERT_NOW(a_fill_bounded, 1'b1, lk_fill_o <= lk_cap_o && lk_wptr_o < lk_cap_o)
  // Only one kind of update is issued at a time.
  `SPBQ_ASSERT_NOW(a_single_cmd, 1'b1, $onehot0({cmd_i.push, cmd_i.pop, cmd_i.clear}))
  // After a clear or a capacity write every level is empty.
  `SPBQ_ASSERT_NEXT(a_clear_empties, cmd_i.clear || cfg_wr_en, !any_ne_o)

endmodule

`default_nettype wire

FILE: rtl/core/strict_priority_block_queue_core.sv
// ---------------------------------------------------------------------------
// Strict-priority block queue core
// Push, pop and clear of short data blocks held in one ring FIFO per
// priority level, level 0 served first.
// ---------------------------------------------------------------------------
// Each operation runs in the idle and execute states: the transfer cycle
// issues the read of the oldest block of the first non-empty level, and
// S_EXEC sees the registered memory data, decides the status and writes
// back pointers, fill count and, on a push, the block itself. This split
// is set by the registered read port of the block memory. A new operation is taken in the
// cycle after the previous one completes, while its result may still sit in
// the output register; an operation waits in S_EXEC only while the
// output register is full and stalled. The block memory needs no clearing
// pass after reset: entries are only read where a push has written them.
// ---------------------------------------------------------------------------
`default_nettype none

module strict_priority_block_queue_core #(
  parameter int LEVELS      = spbq_pkg::DEF_LEVELS,
  parameter int MAX_DEPTH   = spbq_pkg::DEF_MAX_DEPTH,
  parameter int BLOCK_BYTES = spbq_pkg::DEF_BLOCK_BYTES
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire [spbq_pkg::TOTAL_W-1:0]  cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  spbq_pkg::spbq_in_t           in_item,
  output logic                         out_valid,
  input  wire                          out_stall,
  output spbq_pkg::spbq_out_t          out_item
);
  import spbq_pkg::*;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(MAX_DEPTH);
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t       state_r;
  state_t       state_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  spbq_out_t    out_r;
  spbq_in_t     item_r;
  spbq_out_t    res;
  spbq_cmd_t    cmd;
  spbq_entry_t  rd_entry;
  spbq_entry_t  wr_entry;
  logic         accept;
  logic         out_free;
  logic         commit;
  logic         too_long;
  logic         lvl_full;
  logic         room_short;
  logic [LVL_W-1:0]   push_lvl;
  logic [LVL_W-1:0]   pop_lvl;
  logic [LVL_W-1:0]   lk_lvl;
  logic [LVL_W+1:0]   push_lvl_ext;
  logic [LVL_W+1:0]   pop_lvl_ext;
  logic               any_ne;
  logic [PTR_W-1:0]   lk_rptr;
  logic [PTR_W-1:0]   lk_wptr;
  logic [CNT_W-1:0]   lk_fill;
  logic [CNT_W-1:0]   lk_cap;

  // Handshake: one operation at a time, the output register decouples.
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_EXEC) && out_free;

  // Level selection: a push goes to its clamped level, a pop to the first
  // non-empty level. In idle the pop level drives the memory read.
  assign push_lvl = (item_r.priority_req > PRIO_W'(LEVELS - 1)) ?
                    LVL_W'(LEVELS - 1) : LVL_W'(item_r.priority_req);
  assign lk_lvl   = (state_r == S_EXEC && item_r.opcode == OP_PUSH) ? push_lvl : pop_lvl;
  assign push_lvl_ext = (LVL_W + 2)'(push_lvl);
  assign pop_lvl_ext  = (LVL_W + 2)'(pop_lvl);

  spbq_levels #(
    .LEVELS    (LEVELS),
    .MAX_DEPTH (MAX_DEPTH),
    .LVL_W     (LVL_W),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_levels (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .lk_lvl_i    (lk_lvl),
    .cmd_i       (cmd),
    .pop_lvl_o   (pop_lvl),
    .any_ne_o    (any_ne),
    .lk_rptr_o   (lk_rptr),
    .lk_wptr_o   (lk_wptr),
    .lk_fill_o   (lk_fill),
    .lk_cap_o    (lk_cap)
  );

  // Block memory: read at the head of the looked-up level, written at the
  // tail on a successful push.
  assign wr_entry.data = item_r.block_data & byte_mask(OLEN_W'(item_r.block_length));
  assign wr_entry.len  = OLEN_W'(item_r.block_length);

  spbq_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk        (clk),
    .wr_en_i    (cmd.push),
    .wr_addr_i  ({lk_lvl, lk_wptr}),
    .wr_entry_i (wr_entry),
    .rd_addr_i  ({lk_lvl, lk_rptr}),
    .rd_entry_o (rd_entry)
  );

  // Status checks for the operation in flight.
  assign too_long   = (item_r.block_length > LEN_W'(BLOCK_BYTES));
  assign lvl_full   = (lk_fill >= lk_cap);
  assign room_short = (item_r.room < LEN_W'(rd_entry.len));

  // Result and the state update it implies.
  always_comb begin
    res = '0;
    cmd = '0;
    unique case (item_r.opcode)
      OP_PUSH: begin
        res.served_level = push_lvl_ext[SERVED_W-1:0];
        if (too_long) begin
          res.status = ST_LONG;
        end else if (lvl_full) begin
          res.status = ST_FULL;
        end else begin
          cmd.push = commit;
        end
      end
      OP_POP: begin
        if (!any_ne) begin
          res.status = ST_EMPTY;
        end else begin
          res.served_level = pop_lvl_ext[SERVED_W-1:0];
          if (room_short) begin
            res.status = ST_ROOM;
          end else begin
            res.out_data   = rd_entry.data;
            res.out_length = rd_entry.len;
            cmd.pop        = commit;
          end
        end
      end
      OP_CLEAR: begin
        cmd.clear = commit;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Next state and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, captured item and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      item_r <= in_item;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
